>>> rtl/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg
// Types and constants for the line point stepper.
// ---------------------------------------------------------------------------
`default_nettype none

package lps_pkg;

    localparam int COORD_BITS = 12;
    localparam int WIDE_BITS  = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [WIDE_BITS-1:0]  wide_t;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd3
    } dir_t;

    typedef struct packed
    {
        opcode_t opcode;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
    } cmd_t;

    typedef struct packed
    {
        coord_t point_x;
        coord_t point_y;
        logic   last_point;
        logic   no_line;
    } pt_t;

    function automatic coord_t axis_move(input coord_t pos, input dir_t dir);
        coord_t res;
        begin
            case (dir)
                DIR_POS: res = pos + coord_t'(1);
                DIR_NEG: res = pos - coord_t'(1);
                default: res = pos;
            endcase
            return res;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/line_point_stepper.sv
// ---------------------------------------------------------------------------
// line_point_stepper
// Pull-driven line rasterizer: load a segment, then pull one point per step.
// ---------------------------------------------------------------------------
// A step request's point is captured in the result register on the clock after it is taken.
// One request per cycle while no step stalls; the whole error update of both axes is
//   combinational between the line state and the result register.
// Step requests stall only while a point sits in the result register unclaimed;
//   loads are taken regardless.
// Reset: line state clears to idle, result register empties.
`default_nettype none

module line_point_stepper
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire lps_pkg::cmd_t cmd,
    output logic               pt_valid,
    input  wire logic          pt_stall,
    output lps_pkg::pt_t       pt
);

    lps_pkg::coord_t cur_x_reg, cur_x_next;
    lps_pkg::coord_t cur_y_reg, cur_y_next;
    lps_pkg::wide_t  err_x_reg, err_x_next;
    lps_pkg::wide_t  err_y_reg, err_y_next;
    lps_pkg::coord_t abs_dx_reg, abs_dx_next;
    lps_pkg::coord_t abs_dy_reg, abs_dy_next;
    lps_pkg::coord_t major_len_reg, major_len_next;
    lps_pkg::wide_t  points_left_reg, points_left_next;
    lps_pkg::dir_t   dir_x_reg, dir_x_next;
    lps_pkg::dir_t   dir_y_reg, dir_y_next;
    logic            active_reg, active_next;

    logic            pt_valid_reg, pt_valid_next;
    lps_pkg::pt_t    pt_reg, pt_next;

    logic            accept;
    logic            is_step;
    logic            last;
    lps_pkg::wide_t  major_w;
    lps_pkg::wide_t  ex_sum, ey_sum;
    lps_pkg::coord_t ldx, ldy, lmajor;
    lps_pkg::dir_t   ldir_x, ldir_y;

    assign is_step   = (cmd.opcode == lps_pkg::OP_STEP);
    assign cmd_stall = pt_valid_reg && pt_stall && is_step;
    assign accept    = cmd_valid && !cmd_stall;
    assign last      = (points_left_reg <= lps_pkg::wide_t'(1));
    assign major_w   = {1'b0, major_len_reg};
    assign ex_sum    = err_x_reg + {1'b0, abs_dx_reg};
    assign ey_sum    = err_y_reg + {1'b0, abs_dy_reg};

    // load setup
    always_comb
    begin
        if (cmd.end_x > cmd.start_x)
        begin
            ldx    = cmd.end_x - cmd.start_x;
            ldir_x = lps_pkg::DIR_POS;
        end
        else if (cmd.end_x < cmd.start_x)
        begin
            ldx    = cmd.start_x - cmd.end_x;
            ldir_x = lps_pkg::DIR_NEG;
        end
        else
        begin
            ldx    = '0;
            ldir_x = lps_pkg::DIR_NONE;
        end
        if (cmd.end_y > cmd.start_y)
        begin
            ldy    = cmd.end_y - cmd.start_y;
            ldir_y = lps_pkg::DIR_POS;
        end
        else if (cmd.end_y < cmd.start_y)
        begin
            ldy    = cmd.start_y - cmd.end_y;
            ldir_y = lps_pkg::DIR_NEG;
        end
        else
        begin
            ldy    = '0;
            ldir_y = lps_pkg::DIR_NONE;
        end
        lmajor = (ldx > ldy) ? ldx : ldy;
    end

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_x_next       = err_x_reg;
        err_y_next       = err_y_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        major_len_next   = major_len_reg;
        points_left_next = points_left_reg;
        dir_x_next       = dir_x_reg;
        dir_y_next       = dir_y_reg;
        active_next      = active_reg;
        pt_valid_next    = pt_valid_reg && pt_stall;
        pt_next          = pt_reg;

        if (accept)
        begin
            if (!is_step)
            begin
                abs_dx_next      = ldx;
                abs_dy_next      = ldy;
                dir_x_next       = ldir_x;
                dir_y_next       = ldir_y;
                major_len_next   = lmajor;
                err_x_next       = {1'b0, ldx};
                err_y_next       = {1'b0, ldy};
                cur_x_next       = cmd.start_x;
                cur_y_next       = cmd.start_y;
                points_left_next = {1'b0, lmajor} + lps_pkg::wide_t'(1);
                active_next      = 1'b1;
            end
            else if (!active_reg)
            begin
                pt_valid_next = 1'b1;
                pt_next       = '{point_x: '0, point_y: '0, last_point: 1'b0,
                                  no_line: 1'b1};
            end
            else
            begin
                pt_valid_next = 1'b1;
                pt_next       = '{point_x: cur_x_reg, point_y: cur_y_reg,
                                  last_point: last, no_line: 1'b0};
                if (ex_sum > major_w)
                begin
                    err_x_next = ex_sum - major_w;
                    cur_x_next = lps_pkg::axis_move(cur_x_reg, dir_x_reg);
                end
                else
                begin
                    err_x_next = ex_sum;
                end
                if (ey_sum > major_w)
                begin
                    err_y_next = ey_sum - major_w;
                    cur_y_next = lps_pkg::axis_move(cur_y_reg, dir_y_reg);
                end
                else
                begin
                    err_y_next = ey_sum;
                end
                if (last)
                begin
                    points_left_next = '0;
                    active_next      = 1'b0;
                end
                else
                begin
                    points_left_next = points_left_reg - lps_pkg::wide_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            err_x_reg       <= '0;
            err_y_reg       <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            major_len_reg   <= '0;
            points_left_reg <= '0;
            dir_x_reg       <= lps_pkg::DIR_NONE;
            dir_y_reg       <= lps_pkg::DIR_NONE;
            active_reg      <= 1'b0;
            pt_valid_reg    <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            err_x_reg       <= err_x_next;
            err_y_reg       <= err_y_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            major_len_reg   <= major_len_next;
            points_left_reg <= points_left_next;
            dir_x_reg       <= dir_x_next;
            dir_y_reg       <= dir_y_next;
            active_reg      <= active_next;
            pt_valid_reg    <= pt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pt_reg <= pt_next;
    end

    assign pt_valid = pt_valid_reg;
    assign pt       = pt_reg;

    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == (points_left_reg != '0))
        else $error("active flag and point count disagree");

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(accept && is_step && last))
        else $error("line ended without a last point");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_step && active_reg && last |=> !active_reg)
        else $error("line still active after its last point");

    a_no_line_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid_reg && pt_reg.no_line |->
            pt_reg.point_x == '0 && pt_reg.point_y == '0 && !pt_reg.last_point)
        else $error("idle result carries a point");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for line_point_stepper. Loads line segments, pulls
// their points one request at a time and checks every returned point against
// an in-bench error-accumulator line stepper. A directed opening covers the
// corners, lines into all four quadrants, a vertical line, zero-length lines,
// abandoned lines and steps with no line. A random part follows: mostly
// complete short lines, plus long lines cut off by a new load, partial lines
// and stray steps. Both sides pause at random.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 10;
    localparam lps_pkg::coord_t COORD_MAX = '1;

    class point_checker;
        lps_pkg::coord_t cur_x;
        lps_pkg::coord_t cur_y;
        lps_pkg::wide_t  err_x;
        lps_pkg::wide_t  err_y;
        lps_pkg::coord_t span_x;
        lps_pkg::coord_t span_y;
        lps_pkg::coord_t major;
        lps_pkg::wide_t  left;
        lps_pkg::dir_t   dir_x;
        lps_pkg::dir_t   dir_y;
        bit     busy;
        lps_pkg::pt_t    points_due[$];
        int     errors;
        int     loads;
        int     points_ok;
        int     ends_seen;
        int     idle_seen;

        function new();
            cur_x = '0;
            cur_y = '0;
            err_x = '0;
            err_y = '0;
            span_x = '0;
            span_y = '0;
            major = '0;
            left = '0;
            dir_x = lps_pkg::DIR_NONE;
            dir_y = lps_pkg::DIR_NONE;
            busy = 1'b0;
            errors = 0;
            loads = 0;
            points_ok = 0;
            ends_seen = 0;
            idle_seen = 0;
        endfunction

        function lps_pkg::dir_t heading(lps_pkg::coord_t org, lps_pkg::coord_t dst);
            if (dst > org)
                return lps_pkg::DIR_POS;
            if (dst < org)
                return lps_pkg::DIR_NEG;
            return lps_pkg::DIR_NONE;
        endfunction

        function lps_pkg::coord_t span_of(lps_pkg::coord_t org, lps_pkg::coord_t dst);
            return (dst > org) ? dst - org : org - dst;
        endfunction

        function void step_axis(inout lps_pkg::wide_t err, input lps_pkg::coord_t span,
                                inout lps_pkg::coord_t pos, input lps_pkg::dir_t d);
            lps_pkg::wide_t e;
            e = err + span;
            if (e > major)
            begin
                e = e - major;
                if (d == lps_pkg::DIR_POS)
                    pos = pos + 1'b1;
                else if (d == lps_pkg::DIR_NEG)
                    pos = pos - 1'b1;
            end
            err = e;
        endfunction

        function void note_request(lps_pkg::cmd_t c);
            lps_pkg::pt_t p;
            p = '0;
            if (c.opcode == lps_pkg::OP_LOAD)
            begin
                dir_x = heading(c.start_x, c.end_x);
                dir_y = heading(c.start_y, c.end_y);
                span_x = span_of(c.start_x, c.end_x);
                span_y = span_of(c.start_y, c.end_y);
                major = (span_x > span_y) ? span_x : span_y;
                err_x = span_x;
                err_y = span_y;
                cur_x = c.start_x;
                cur_y = c.start_y;
                left = lps_pkg::wide_t'(major) + 1'b1;
                busy = 1'b1;
                loads++;
            end
            else if (!busy)
            begin
                p.no_line = 1'b1;
                points_due.push_back(p);
            end
            else
            begin
                p.point_x = cur_x;
                p.point_y = cur_y;
                p.last_point = (left <= 1);
                points_due.push_back(p);
                step_axis(err_x, span_x, cur_x, dir_x);
                step_axis(err_y, span_y, cur_y, dir_y);
                if (left <= 1)
                begin
                    left = '0;
                    busy = 1'b0;
                end
                else
                    left = left - 1'b1;
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            errors++;
        endtask

        task check_point(lps_pkg::pt_t got);
            lps_pkg::pt_t want;
            bit bad;
            if (points_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected point %p", got));
                return;
            end
            want = points_due.pop_front();
            bad = 1'b0;
            if (got.point_x !== want.point_x)
            begin
                report_mismatch($sformatf("point_x got %0d expected %0d",
                                          got.point_x, want.point_x));
                bad = 1'b1;
            end
            if (got.point_y !== want.point_y)
            begin
                report_mismatch($sformatf("point_y got %0d expected %0d",
                                          got.point_y, want.point_y));
                bad = 1'b1;
            end
            if (got.last_point !== want.last_point)
            begin
                report_mismatch($sformatf("last_point got %b expected %b",
                                          got.last_point, want.last_point));
                bad = 1'b1;
            end
            if (got.no_line !== want.no_line)
            begin
                report_mismatch($sformatf("no_line got %b expected %b",
                                          got.no_line, want.no_line));
                bad = 1'b1;
            end
            if (!bad)
            begin
                if (want.no_line)
                    idle_seen++;
                else
                    points_ok++;
                if (want.last_point)
                    ends_seen++;
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    lps_pkg::cmd_t cmd = '0;
    logic pt_valid;
    logic pt_stall = 1'b0;
    lps_pkg::pt_t  pt;

    point_checker sb;
    int sent = 0;
    int unsigned cycles = 0;
    int unsigned run_left = 0;

    line_point_stepper dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .pt_valid  (pt_valid),
        .pt_stall  (pt_stall),
        .pt        (pt)
    );

    always #5 clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // receiver: stall bursts alternate with flow runs, some of them long
    always @(posedge clk)
    begin
        if (run_left != 0)
            run_left <= run_left - 1;
        else if (pt_stall)
        begin
            pt_stall <= 1'b0;
            run_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                                    : $urandom_range(0, 6);
        end
        else
        begin
            pt_stall <= 1'b1;
            run_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pt_valid && !pt_stall)
            sb.check_point(pt);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d points outstanding",
                     cycles, sb.points_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_cmd(lps_pkg::cmd_t c);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_request(c);
        sent++;
    endtask

    function automatic lps_pkg::cmd_t make_step();
        lps_pkg::cmd_t s;
        s.opcode = lps_pkg::OP_STEP;
        s.start_x = lps_pkg::coord_t'($urandom);
        s.start_y = lps_pkg::coord_t'($urandom);
        s.end_x = lps_pkg::coord_t'($urandom);
        s.end_y = lps_pkg::coord_t'($urandom);
        return s;
    endfunction

    task automatic draw_line(lps_pkg::coord_t sx, lps_pkg::coord_t sy,
                             lps_pkg::coord_t ex, lps_pkg::coord_t ey,
                             int unsigned steps);
        lps_pkg::cmd_t c;
        c.opcode = lps_pkg::OP_LOAD;
        c.start_x = sx;
        c.start_y = sy;
        c.end_x = ex;
        c.end_y = ey;
        send_cmd(c);
        repeat (steps)
            send_cmd(make_step());
    endtask

    // hold requests until every outstanding point has come back
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.points_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic lps_pkg::coord_t near(lps_pkg::coord_t org, int unsigned reach);
        int d;
        int t;
        d = int'($urandom_range(0, 2 * reach)) - int'(reach);
        t = int'(org) + d;
        if (t < 0 || t > int'(COORD_MAX))
            t = int'(org) - d;
        return lps_pkg::coord_t'(t);
    endfunction

    initial
    begin
        int stop_at;
        int unsigned pick;
        int unsigned reach;
        int ax;
        int ay;
        int span;
        bit paused;
        lps_pkg::coord_t sx;
        lps_pkg::coord_t sy;
        lps_pkg::coord_t ex;
        lps_pkg::coord_t ey;

        sb = new();
        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed opening
        send_cmd(make_step());
        draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1);
        send_cmd(make_step());
        draw_line(0, 0, 3, 1, 4);
        draw_line(COORD_MAX, 0, COORD_MAX - 3, 2, 4);
        draw_line(10, COORD_MAX, 10, COORD_MAX - 1, 2);
        draw_line(0, 0, COORD_MAX, COORD_MAX, 2);
        draw_line(COORD_MAX, COORD_MAX, 0, 0, 2);
        draw_line(0, COORD_MAX, COORD_MAX, 0, 1);
        wait_drained();

        stop_at = sent + RANDOM_ITEMS;
        while (sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            reach = ($urandom_range(0, 9) == 0) ? 60 : 12;
            sx = lps_pkg::coord_t'($urandom);
            sy = lps_pkg::coord_t'($urandom);
            ex = near(sx, reach);
            ey = near(sy, reach);
            ax = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
            ay = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
            span = (ax > ay) ? ax : ay;
            if (pick < 70)
            begin
                draw_line(sx, sy, ex, ey, span + 1);
                if ($urandom_range(0, 6) == 0)
                    send_cmd(make_step());
            end
            else if (pick < 85)
                draw_line(sx, sy, lps_pkg::coord_t'($urandom),
                          lps_pkg::coord_t'($urandom), $urandom_range(0, 8));
            else if (pick < 95)
                draw_line(sx, sy, ex, ey, $urandom_range(0, span));
            else
                repeat ($urandom_range(1, 3))
                    send_cmd(make_step());

            if ((!paused && sent >= stop_at - RANDOM_ITEMS / 2)
                || $urandom_range(0, 39) == 0)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end

        cmd_valid <= 1'b0;
        while (sb.points_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d line loads, %0d points returned",
                 sent, sb.loads, sb.points_ok);
        $display("Line ends flagged: %0d, idle replies: %0d, mismatches: %0d",
                 sb.ends_seen, sb.idle_seen, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
